// File: sv/stereo_linear_resampler_top_defines.svh
// Assertion macros shared by the stereo resampler RTL.
`ifndef STEREO_LINEAR_RESAMPLER_TOP_DEFINES_SVH
`define STEREO_LINEAR_RESAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and switched off while rst_ni is low.
`define SRL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srl: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and switched off while rst_ni is low.
`define SRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srl: next-cycle check failed");

`endif

// File: sv/srl_pkg.sv
// Types and constants shared by the stereo linear resampler modules.
`default_nettype none
package srl_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned RATE_W        = 18;
  localparam int unsigned INT_BITS      = 8;
  localparam int unsigned STEP_HEAD     = 5;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned MAX_OUT       = 25;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned TDATA_W       = 32;
  localparam int unsigned RATE_IN_RST   = 44100;
  localparam int unsigned RATE_OUT_RST  = 48000;

  // Register index, taken from paddr bit 2.
  localparam logic REG_INPUT_RATE  = 1'b0;
  localparam logic REG_OUTPUT_RATE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_BYP,
    S_MUL_L,
    S_MUL_R,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic en;
    logic sel_right;
  } mul_ctrl_t;

endpackage
`default_nettype wire

// File: sv/srl_div.sv
// Bit-serial restoring divider that turns the two rates into the saturated phase step.
`default_nettype none
module srl_div
  import srl_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [RATE_W-1:0]             num_rate_i,
  input  wire logic [RATE_W-1:0]             den_rate_i,
  output div_stat_t                          stat_o,
  output logic      [FRAC_BITS+STEP_HEAD-1:0] step_o
);

  localparam int unsigned QW     = RATE_W + FRAC_BITS;
  localparam int unsigned STEP_W = FRAC_BITS + STEP_HEAD;
  localparam int unsigned CW     = $clog2(QW);

  logic              busy_q, done_q;
  logic [CW-1:0]     cnt_q;
  logic [RATE_W-1:0] rem_q;
  logic [RATE_W-1:0] den_q;
  logic [QW-1:0]     quo_q;
  logic [RATE_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, quo_q[QW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_rate_i;
      quo_q <= {num_rate_i, {FRAC_BITS{1'b0}}};
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= RATE_W'(trial - {1'b0, den_q});
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= trial[RATE_W-1:0];
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
  end

  // A zero divisor leaves every quotient bit set, so it saturates like an oversized step.
  assign step_o = (|quo_q[QW-1:STEP_W]) ? {STEP_W{1'b1}} : quo_q[STEP_W-1:0];
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule
`default_nettype wire

// File: sv/srl_interp.sv
// Shared multiplier and adder that interpolates the left and then the right channel.
`default_nettype none
module srl_interp
  import srl_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire mul_ctrl_t                  ctrl_i,
  input  wire logic signed [SAMPLE_W-1:0] prev_l_i,
  input  wire logic signed [SAMPLE_W-1:0] prev_r_i,
  input  wire logic signed [SAMPLE_W-1:0] cur_l_i,
  input  wire logic signed [SAMPLE_W-1:0] cur_r_i,
  input  wire logic        [FRAC_BITS-1:0] frac_i,
  output logic        [SAMPLE_W-1:0]      res_l_o,
  output logic        [SAMPLE_W-1:0]      res_r_o
);

  localparam int unsigned DW  = SAMPLE_W + 1;
  localparam int unsigned PRW = DW + FRAC_BITS + 1;
  localparam int unsigned SW  = SAMPLE_W + 2;

  logic signed [DW-1:0]        diff;
  logic signed [FRAC_BITS:0]   frac_s;
  logic signed [PRW-1:0]       prod_d, prod_q;
  logic signed [PRW-1:0]       prod_sh;
  logic signed [SAMPLE_W-1:0]  prev_sel;
  logic        [SW-1:0]        sum;
  logic                        sel_q;
  logic        [SAMPLE_W-1:0]  left_q;

  always_comb begin
    if (ctrl_i.sel_right) begin
      diff = DW'(cur_r_i) - DW'(prev_r_i);
    end else begin
      diff = DW'(cur_l_i) - DW'(prev_l_i);
    end
  end

  assign frac_s = {1'b0, frac_i};
  assign prod_d = PRW'(diff) * PRW'(frac_s);

  // The arithmetic shift of the registered product gives the floored quotient.
  assign prod_sh  = prod_q >>> FRAC_BITS;
  assign prev_sel = sel_q ? prev_r_i : prev_l_i;
  assign sum      = SW'(prev_sel) + prod_sh[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (ctrl_i.en) begin
      sel_q <= ctrl_i.sel_right;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= prod_d;
      if (ctrl_i.sel_right) begin
        left_q <= sum[SAMPLE_W-1:0];
      end
    end
  end

  assign res_l_o = left_q;
  assign res_r_o = sum[SAMPLE_W-1:0];

endmodule
`default_nettype wire

// File: sv/stereo_linear_resampler_top.sv
// Stereo linear-interpolation resampler: sequencer, state, register port and output stage.
// Each accepted beat is one signed 16-bit stereo frame; each output beat is one frame, with
// tlast on the last frame that input frame produced. With equal rates a frame passes
// straight through. Otherwise an input frame produces no output or n frames (at most 25):
// a single multiplier serves both channels, so each output frame takes a left multiply
// step, a right multiply step and an emit step. One finished frame can wait in the output
// register while the block goes on. A write to a rate register starts, once the block is
// idle, a bit-serial division that computes the phase step; no input beat is accepted
// until it ends.
`default_nettype none
`include "stereo_linear_resampler_top_defines.svh"
module stereo_linear_resampler_top
  import srl_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // APB register port
  input  wire logic               psel_i,
  input  wire logic               penable_i,
  input  wire logic               pwrite_i,
  input  wire logic [ADDR_W-1:0]  paddr_i,
  input  wire logic [DATA_W-1:0]  pwdata_i,
  output logic      [DATA_W-1:0]  prdata_o,
  output logic                    pready_o,
  // Input frames
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [TDATA_W-1:0] s_axis_tdata_i,   // [15:0] left_sample, [31:16] right_sample
  // Output frames
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic      [TDATA_W-1:0] m_axis_tdata_o,   // [15:0] out_left, [31:16] out_right
  output logic                    m_axis_tlast_o
);

  localparam int unsigned PW     = FRAC_BITS + INT_BITS;
  localparam int unsigned STEP_W = FRAC_BITS + STEP_HEAD;
  localparam longint unsigned STEP_FULL = (longint'(RATE_IN_RST) << FRAC_BITS)
                                          / longint'(RATE_OUT_RST);
  localparam longint unsigned STEP_CAP  = (longint'(1) << STEP_W) - 1;
  localparam logic [STEP_W-1:0] STEP_RST =
    STEP_W'((STEP_FULL > STEP_CAP) ? STEP_CAP : STEP_FULL);
  localparam logic [PW-1:0] ONE_UNIT = {{(INT_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  state_e state_q, state_d;

  logic [RATE_W-1:0]          input_rate_q, output_rate_q;
  logic                       cfg_upd_q;
  logic [STEP_W-1:0]          step_q;
  logic [PW-1:0]              phase_q;
  logic signed [SAMPLE_W-1:0] prev_l_q, prev_r_q, cur_l_q, cur_r_q;
  logic                       primed_q;
  logic [CNT_W-1:0]           cnt_q;

  logic                       out_valid_q;
  logic [SAMPLE_W-1:0]        out_l_q, out_r_q;
  logic                       out_last_q;

  logic                       cfg_wr, in_fire, bypass, int_zero, out_free;
  logic                       emit_fire, emit_last, byp_fire, div_start;
  logic [PW-1:0]              phase_sum;
  logic signed [SAMPLE_W-1:0] in_l, in_r;
  logic [SAMPLE_W-1:0]        res_l, res_r;
  logic [STEP_W-1:0]          div_step;
  div_stat_t                  div_stat;
  mul_ctrl_t                  mul_ctrl;

  assign cfg_wr    = psel_i && penable_i && pwrite_i && pready_o;
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign bypass    = input_rate_q == output_rate_q;
  assign int_zero  = phase_q[PW-1:FRAC_BITS] == '0;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign phase_sum = phase_q + PW'(step_q);
  assign emit_last = (cnt_q == CNT_W'(MAX_OUT - 1)) || (phase_sum[PW-1:FRAC_BITS] != '0);
  assign in_l      = s_axis_tdata_i[SAMPLE_W-1:0];
  assign in_r      = s_axis_tdata_i[2*SAMPLE_W-1:SAMPLE_W];

  // Register read-back.
  always_comb begin
    unique case (paddr_i[2])
      REG_INPUT_RATE:  prdata_o = DATA_W'(input_rate_q);
      REG_OUTPUT_RATE: prdata_o = DATA_W'(output_rate_q);
      default:         prdata_o = '0;
    endcase
  end
  assign pready_o = 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cfg_upd_q) begin
          state_d = S_DIV;
        end else if (in_fire) begin
          if (bypass) begin
            state_d = S_BYP;
          end else if (int_zero) begin
            state_d = S_MUL_L;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_IDLE;
        end
      end
      S_BYP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_MUL_L: state_d = S_MUL_R;
      S_MUL_R: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = emit_last ? S_IDLE : S_MUL_L;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready_o    = 1'b0;
    div_start          = 1'b0;
    mul_ctrl.en        = 1'b0;
    mul_ctrl.sel_right = 1'b0;
    emit_fire          = 1'b0;
    byp_fire           = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = !cfg_upd_q;
        div_start       = cfg_upd_q;
      end
      S_DIV: ;
      S_BYP:   byp_fire = out_free;
      S_MUL_L: mul_ctrl.en = 1'b1;
      S_MUL_R: begin
        mul_ctrl.en        = 1'b1;
        mul_ctrl.sel_right = 1'b1;
      end
      S_EMIT:  emit_fire = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      input_rate_q  <= RATE_W'(RATE_IN_RST);
      output_rate_q <= RATE_W'(RATE_OUT_RST);
      cfg_upd_q     <= 1'b0;
      step_q        <= STEP_RST;
      phase_q       <= '0;
      prev_l_q      <= '0;
      prev_r_q      <= '0;
      primed_q      <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_wr) begin
        if (paddr_i[2] == REG_INPUT_RATE) begin
          input_rate_q <= pwdata_i[RATE_W-1:0];
        end else begin
          output_rate_q <= pwdata_i[RATE_W-1:0];
        end
      end
      if (cfg_wr) begin
        cfg_upd_q <= 1'b1;
      end else if (div_start) begin
        cfg_upd_q <= 1'b0;
      end
      if (div_stat.done) begin
        step_q <= div_step;
      end

      if (in_fire && !bypass) begin
        cnt_q <= '0;
        // A frame that yields nothing still moves the phase on and becomes the previous one.
        if (!int_zero) begin
          phase_q  <= phase_q - ONE_UNIT;
          prev_l_q <= in_l;
          prev_r_q <= in_r;
        end else if (!primed_q) begin
          prev_l_q <= in_l;
          prev_r_q <= in_r;
        end
        primed_q <= 1'b1;
      end else if (emit_fire) begin
        cnt_q   <= cnt_q + 1'b1;
        phase_q <= (phase_sum[PW-1:FRAC_BITS] != '0) ? phase_sum - ONE_UNIT : phase_sum;
        if (emit_last) begin
          prev_l_q <= cur_l_q;
          prev_r_q <= cur_r_q;
        end
      end

      if (emit_fire || byp_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cur_l_q <= in_l;
      cur_r_q <= in_r;
    end
    if (byp_fire) begin
      out_l_q    <= cur_l_q;
      out_r_q    <= cur_r_q;
      out_last_q <= 1'b1;
    end else if (emit_fire) begin
      out_l_q    <= res_l;
      out_r_q    <= res_r;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_r_q, out_l_q};
  assign m_axis_tlast_o  = out_last_q;

  srl_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .num_rate_i (input_rate_q),
    .den_rate_i (output_rate_q),
    .stat_o     (div_stat),
    .step_o     (div_step)
  );

  srl_interp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_interp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mul_ctrl),
    .prev_l_i (prev_l_q),
    .prev_r_i (prev_r_q),
    .cur_l_i  (cur_l_q),
    .cur_r_i  (cur_r_q),
    .frac_i   (phase_q[FRAC_BITS-1:0]),
    .res_l_o  (res_l),
    .res_r_o  (res_r)
  );

  `SRL_ASSERT_IMPL(a_emit_below_cap, state_q == S_EMIT, cnt_q < CNT_W'(MAX_OUT))
  `SRL_ASSERT_IMPL(a_no_accept_in_div, in_fire, !div_stat.busy)
  `SRL_ASSERT_NEXT(a_last_ends_item, emit_fire && emit_last, state_q == S_IDLE && m_axis_tlast_o)

endmodule
`default_nettype wire
